FILE: hdl/hop_pkg.sv
package hop_pkg;

	localparam int UNITS_DEF         = 128;
	localparam int PATTERN_LIMIT_DEF = 15;

	localparam int REQ_W    = 3;
	localparam int IDX_IN_W = 7;
	localparam int SUM_W    = 12;

	localparam logic [REQ_W-1:0] REQ_LOAD   = 3'd0;
	localparam logic [REQ_W-1:0] REQ_COMMIT = 3'd1;
	localparam logic [REQ_W-1:0] REQ_SET    = 3'd2;
	localparam logic [REQ_W-1:0] REQ_UPDATE = 3'd3;
	localparam logic [REQ_W-1:0] REQ_READ   = 3'd4;
	localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd5;

	localparam logic signed [SUM_W-1:0] SUM_MAX = 12'sd2047;
	localparam logic signed [SUM_W-1:0] SUM_MIN = -12'sd2048;

	typedef enum logic [1:0] {
		WOP_IDLE,
		WOP_CLEAR,
		WOP_COMMIT
	} wop_t;

	// Command from the sequencer to the weight and pattern store.
	typedef struct packed {
		wop_t op;
		logic diag;
		logic pat_we;
		logic pat_bit;
	} wcmd_t;

endpackage

FILE: hdl/hopfield_associative_memory.sv
// A load, set, read or unknown request goes from its transfer straight to the done state;
// an update walks its weight row, drains and decides; a commit or clear sweeps the store.
// One request is in flight at a time, so the next transfer is taken in the cycle after the
// result is registered. The weight memory port reads one entry per cycle, so an update
// costs one weight row and a commit or clear the whole store. Reset is asynchronous, active
// low; a clearing pass then zeroes weights and states, taking no request.
module hopfield_associative_memory #(
	parameter int UNITS         = hop_pkg::UNITS_DEF,
	parameter int PATTERN_LIMIT = hop_pkg::PATTERN_LIMIT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic signed [hop_pkg::SUM_W-1:0] cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [hop_pkg::REQ_W-1:0]        req_type,
	input  logic [hop_pkg::IDX_IN_W-1:0]     unit_index,
	input  logic                             bit_value,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             unit_state,
	output logic                             changed,
	output logic signed [hop_pkg::SUM_W-1:0] field_sum
);
	import hop_pkg::*;

	localparam int IDX_W    = $clog2(UNITS);
	localparam int ADDR_W   = $clog2(UNITS * UNITS);
	localparam int WEIGHT_W = $clog2(PATTERN_LIMIT + 1) + 1;
	// The largest possible row sum sets the accumulator width.
	localparam int ACC_W    = $clog2(UNITS * PATTERN_LIMIT + 1) + 1;
	localparam int EW       = (ACC_W > SUM_W) ? ACC_W : SUM_W;
	localparam int XW       = (IDX_W > IDX_IN_W) ? IDX_W : IDX_IN_W;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(UNITS - 1);

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLEAR,
		ST_COMMIT,
		ST_UPDATE,
		ST_DRAIN,
		ST_DECIDE,
		ST_DONE
	} state_t;

	state_t state_q;

	// Request held for the duration of its processing.
	logic [REQ_W-1:0] req_q;
	logic [IDX_W-1:0] idx_q;
	logic             idx_ok_q;
	logic             bit_q;

	// Sweep counters shared by the clearing pass, the clear, the commit and the update row walk.
	logic [IDX_W-1:0]  row_q;
	logic [IDX_W-1:0]  col_q;
	logic [ADDR_W-1:0] addr_q;

	logic signed [ACC_W-1:0] acc_q;
	logic                    upd_v_s1;
	logic                    upd_state_q;
	logic                    changed_q;
	logic signed [SUM_W-1:0] sum_q;
	logic signed [SUM_W-1:0] thr_q;

	logic                    out_valid_q;
	logic                    unit_state_q;
	logic                    changed_out_q;
	logic signed [SUM_W-1:0] field_sum_q;

	logic [XW-1:0]    idx_wide;
	logic [IDX_W-1:0] idx_in;
	logic             idx_ok;
	logic             accept;
	logic             sweep_last;
	logic             row_last;

	wcmd_t                      wcmd;
	logic [IDX_W-1:0]           pat_row;
	logic signed [WEIGHT_W-1:0] w_rdata;

	// Unit state memory: port A walks the row during an update, port B follows the
	// addressed unit.
	logic             smem [UNITS];
	logic             sa_rd;
	logic             sb_rd;
	logic [IDX_W-1:0] sb_addr;
	logic             s_we;
	logic [IDX_W-1:0] s_waddr;
	logic             s_wdata;

	logic signed [EW-1:0]    acc_e;
	logic signed [SUM_W-1:0] sum_sat;
	logic                    new_state;
	logic                    res_state;

	assign idx_wide   = XW'(unit_index);
	assign idx_in     = idx_wide[IDX_W-1:0];
	assign idx_ok     = (32'(unit_index) < UNITS);
	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign cfg_ready  = 1'b1;
	assign row_last   = (col_q == IDX_LAST);
	assign sweep_last = row_last && (row_q == IDX_LAST);

	// The threshold is to be written only while the block is idle; the block itself does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			thr_q <= cfg_data;
		end
	end

	// Commands to the weight and pattern store.
	always_comb begin
		wcmd.op      = WOP_IDLE;
		wcmd.diag    = (row_q == col_q);
		wcmd.pat_we  = accept && (req_type == REQ_LOAD) && idx_ok;
		wcmd.pat_bit = bit_value;
		if (state_q == ST_INIT || state_q == ST_CLEAR) begin
			wcmd.op = WOP_CLEAR;
		end else if (state_q == ST_COMMIT) begin
			wcmd.op = WOP_COMMIT;
		end
		pat_row = (state_q == ST_IDLE) ? idx_in : row_q;
	end

	hop_store #(
		.UNITS         (UNITS),
		.PATTERN_LIMIT (PATTERN_LIMIT)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (wcmd),
		.w_addr  (addr_q),
		.pat_row (pat_row),
		.pat_col (col_q),
		.w_rdata (w_rdata)
	);

	// Saturate the row sum and compare it with the threshold; a tie keeps the state.
	always_comb begin
		acc_e = EW'(acc_q);
		if (acc_e > EW'(SUM_MAX)) begin
			sum_sat = SUM_MAX;
		end else if (acc_e < EW'(SUM_MIN)) begin
			sum_sat = SUM_MIN;
		end else begin
			sum_sat = SUM_W'(acc_e);
		end
		if (sum_sat != thr_q) begin
			new_state = (sum_sat > thr_q);
		end else begin
			new_state = sb_rd;
		end
	end

	// One write port on the state memory: the reset pass, a set request at its transfer,
	// or the decision at the end of an update. These never fall in the same cycle.
	always_comb begin
		s_we    = 1'b0;
		s_waddr = idx_q;
		s_wdata = 1'b0;
		sb_addr = (state_q == ST_IDLE) ? idx_in : idx_q;
		if (state_q == ST_INIT) begin
			s_we    = (row_q == '0);
			s_waddr = col_q;
		end else if (state_q == ST_DECIDE) begin
			s_we    = idx_ok_q;
			s_wdata = new_state;
		end else if (accept && req_type == REQ_SET && idx_ok) begin
			s_we    = 1'b1;
			s_waddr = idx_in;
			s_wdata = bit_value;
		end
	end

	always_ff @(posedge clk) begin
		if (s_we) begin
			smem[s_waddr] <= s_wdata;
		end
		sa_rd <= smem[col_q];
		sb_rd <= smem[sb_addr];
	end

	// Result of the finished request. A set reports the written bit; all other
	// requests but an update report the unit's stored state; an index out of range reports zero.
	always_comb begin
		if (!idx_ok_q) begin
			res_state = 1'b0;
		end else if (req_q == REQ_SET) begin
			res_state = bit_q;
		end else if (req_q == REQ_UPDATE) begin
			res_state = upd_state_q;
		end else begin
			res_state = sb_rd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_INIT;
			req_q         <= REQ_READ;
			idx_q         <= '0;
			idx_ok_q      <= 1'b0;
			bit_q         <= 1'b0;
			row_q         <= '0;
			col_q         <= '0;
			addr_q        <= '0;
			acc_q         <= '0;
			upd_v_s1      <= 1'b0;
			upd_state_q   <= 1'b0;
			changed_q     <= 1'b0;
			sum_q         <= '0;
			out_valid_q   <= 1'b0;
			unit_state_q  <= 1'b0;
			changed_out_q <= 1'b0;
			field_sum_q   <= '0;
		end else begin
			upd_v_s1 <= (state_q == ST_UPDATE);
			// Weight and state data of one column arrive together in the cycle after the read.
			if (upd_v_s1) begin
				acc_q <= sa_rd ? acc_q + ACC_W'(w_rdata) : acc_q - ACC_W'(w_rdata);
			end
			// In the done state the output register is either refilled or left stalled.
			if (out_valid_q && out_ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_INIT, ST_CLEAR, ST_COMMIT: begin
					addr_q <= addr_q + ADDR_W'(1);
					col_q  <= row_last ? '0 : col_q + IDX_W'(1);
					if (row_last) begin
						row_q <= row_q + IDX_W'(1);
					end
					if (sweep_last) begin
						state_q <= (state_q == ST_INIT) ? ST_IDLE : ST_DONE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						req_q    <= req_type;
						idx_q    <= idx_in;
						idx_ok_q <= idx_ok;
						bit_q    <= bit_value;
						row_q    <= '0;
						col_q    <= '0;
						// An update starts its walk at the first entry of the unit's row.
						addr_q   <= (req_type == REQ_UPDATE) ? ADDR_W'(idx_in * UNITS) : '0;
						acc_q    <= '0;
						if (req_type == REQ_COMMIT) begin
							state_q <= ST_COMMIT;
						end else if (req_type == REQ_CLEAR) begin
							state_q <= ST_CLEAR;
						end else if (req_type == REQ_UPDATE && idx_ok) begin
							state_q <= ST_UPDATE;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_UPDATE: begin
					addr_q <= addr_q + ADDR_W'(1);
					col_q  <= col_q + IDX_W'(1);
					if (row_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					upd_state_q <= new_state;
					changed_q   <= (new_state != sb_rd);
					sum_q       <= sum_sat;
					state_q     <= ST_DONE;
				end
				ST_DONE: begin
					// The output register takes the result once the previous one has gone.
					if (!out_valid_q || out_ready) begin
						out_valid_q   <= 1'b1;
						unit_state_q  <= res_state;
						changed_out_q <= (req_q == REQ_UPDATE) && idx_ok_q && changed_q;
						field_sum_q   <= (req_q == REQ_UPDATE && idx_ok_q) ? sum_q : '0;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign unit_state = unit_state_q;
	assign changed    = changed_out_q;
	assign field_sum  = field_sum_q;

endmodule

FILE: hdl/hop_store.sv
module hop_store #(
	parameter int UNITS         = hop_pkg::UNITS_DEF,
	parameter int PATTERN_LIMIT = hop_pkg::PATTERN_LIMIT_DEF,
	localparam int WEIGHT_W     = $clog2(PATTERN_LIMIT + 1) + 1,
	localparam int IDX_W        = $clog2(UNITS),
	localparam int ADDR_W       = $clog2(UNITS * UNITS)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  hop_pkg::wcmd_t             cmd,
	input  logic [ADDR_W-1:0]          w_addr,
	input  logic [IDX_W-1:0]           pat_row,
	input  logic [IDX_W-1:0]           pat_col,
	output logic signed [WEIGHT_W-1:0] w_rdata
);
	import hop_pkg::*;

	localparam int DEPTH = UNITS * UNITS;
	localparam logic signed [WEIGHT_W:0] LIM_POS = (WEIGHT_W + 1)'(PATTERN_LIMIT);
	localparam logic signed [WEIGHT_W:0] LIM_NEG = -LIM_POS;

	logic signed [WEIGHT_W-1:0] wmem [DEPTH];
	logic                       pmem [UNITS];

	logic signed [WEIGHT_W-1:0] w_rd;
	logic                       pr_rd;
	logic                       pc_rd;

	wop_t              op_s1;
	logic              diag_s1;
	logic [ADDR_W-1:0] addr_s1;

	logic signed [WEIGHT_W:0]   w_sum;
	logic signed [WEIGHT_W-1:0] w_next;
	logic                       w_we;
	logic [ADDR_W-1:0]          w_waddr;
	logic signed [WEIGHT_W-1:0] w_wdata;

	// Hebbian step: equal pattern bits add one, differing bits subtract one.
	always_comb begin
		w_sum = (pr_rd == pc_rd) ? (WEIGHT_W + 1)'(w_rd) + (WEIGHT_W + 1)'(1)
			: (WEIGHT_W + 1)'(w_rd) - (WEIGHT_W + 1)'(1);
		if (w_sum > LIM_POS) begin
			w_next = WEIGHT_W'(LIM_POS);
		end else if (w_sum < LIM_NEG) begin
			w_next = WEIGHT_W'(LIM_NEG);
		end else begin
			w_next = WEIGHT_W'(w_sum);
		end
	end

	always_comb begin
		w_we    = 1'b0;
		w_waddr = w_addr;
		w_wdata = '0;
		if (cmd.op == WOP_CLEAR) begin
			w_we = 1'b1;
		end else if (op_s1 == WOP_COMMIT && !diag_s1) begin
			w_we    = 1'b1;
			w_waddr = addr_s1;
			w_wdata = w_next;
		end
	end

	always_ff @(posedge clk) begin
		if (w_we) begin
			wmem[w_waddr] <= w_wdata;
		end
		w_rd <= wmem[w_addr];
		if (cmd.pat_we) begin
			pmem[pat_row] <= cmd.pat_bit;
		end
		pr_rd <= pmem[pat_row];
		pc_rd <= pmem[pat_col];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1   <= WOP_IDLE;
			diag_s1 <= 1'b0;
			addr_s1 <= '0;
		end else begin
			op_s1   <= cmd.op;
			diag_s1 <= cmd.diag;
			addr_s1 <= w_addr;
		end
	end

	assign w_rdata = w_rd;

endmodule

FILE: dv/hopfield_associative_memory_tb.sv
`timescale 1ns / 1ps

module hopfield_associative_memory_tb;
	import hop_pkg::*;

	localparam int UNITS         = UNITS_DEF;
	localparam int PATTERN_LIMIT = PATTERN_LIMIT_DEF;

	// The two request codes the block does not define; they must leave all state alone.
	localparam logic [REQ_W-1:0] REQ_SPARE_A = 3'd6;
	localparam logic [REQ_W-1:0] REQ_SPARE_B = 3'd7;

	// A commit or clear walks the whole weight store, and so does the clearing pass after
	// reset. About two dozen of those plus a few hundred row updates and the receiver
	// stalls make up most of the run; the watchdog allows a wide margin on that.
	localparam int CYCLE_LIMIT  = 2_500_000;
	localparam int COMMIT_MAX   = 20;
	localparam int CLEAR_MAX    = 3;
	localparam int PHASE_ITEMS  = 60;
	localparam int SETTLE_CYCLES = 8;

	typedef struct {
		logic                    unit_state;
		logic                    changed;
		logic signed [SUM_W-1:0] field_sum;
	} unit_result_t;

	// Predicts the result of every accepted request from its own copy of the unit states,
	// the pattern buffer, the weights and the threshold, and checks the results in order.
	class hopfield_predictor;
		bit                  pattern [UNITS];
		bit                  states [UNITS];
		logic signed [4:0]   weights [UNITS][UNITS];
		int                  threshold;
		unit_result_t        expected_results[$];
		int                  errors;
		int                  n_checked;
		int                  n_updates;
		int                  n_flips;
		int                  n_ties;
		int                  n_commits;
		int                  n_clears;
		int                  n_thresholds;

		function new();
			foreach (states[i]) begin
				states[i]  = 1'b0;
				pattern[i] = 1'b0;
			end
			foreach (weights[r, c])
				weights[r][c] = '0;
			threshold = 0;
		endfunction

		function void set_threshold(logic signed [SUM_W-1:0] value);
			threshold = value;
			n_thresholds++;
		endfunction

		function void note_request(logic [REQ_W-1:0] req, logic [IDX_IN_W-1:0] idx, logic bv);
			unit_result_t exp_res;
			int           acc;
			int           w;
			exp_res.changed   = 1'b0;
			exp_res.field_sum = '0;
			case (req)
				REQ_LOAD: pattern[idx] = bv;
				REQ_SET:  states[idx] = bv;
				REQ_CLEAR: begin
					foreach (weights[r, c])
						weights[r][c] = '0;
					n_clears++;
				end
				REQ_COMMIT: begin
					// Hebbian outer product of the bipolar pattern, no self-connections.
					for (int r = 0; r < UNITS; r++) begin
						for (int c = 0; c < UNITS; c++) begin
							if (r != c) begin
								w = int'(weights[r][c]) + ((pattern[r] == pattern[c]) ? 1 : -1);
								if (w > PATTERN_LIMIT)
									w = PATTERN_LIMIT;
								if (w < -PATTERN_LIMIT)
									w = -PATTERN_LIMIT;
								weights[r][c] = w[4:0];
							end
						end
					end
					n_commits++;
				end
				REQ_UPDATE: begin
					acc = 0;
					for (int c = 0; c < UNITS; c++)
						acc += states[c] ? int'(weights[idx][c]) : -int'(weights[idx][c]);
					if (acc > SUM_MAX)
						acc = SUM_MAX;
					if (acc < SUM_MIN)
						acc = SUM_MIN;
					exp_res.field_sum = acc[SUM_W-1:0];
					n_updates++;
					if (acc == threshold) begin
						n_ties++;
					end else if ((acc > threshold) != states[idx]) begin
						states[idx]     = (acc > threshold);
						exp_res.changed = 1'b1;
						n_flips++;
					end
				end
				default: ;
			endcase
			exp_res.unit_state = states[idx];
			expected_results.push_back(exp_res);
		endfunction

		function void check_result(logic st, logic ch, logic signed [SUM_W-1:0] fs);
			unit_result_t exp_res;
			if (expected_results.size() == 0) begin
				$display("%0t: result with no request outstanding (state %0d changed %0d sum %0d)",
					$time, st, ch, fs);
				errors++;
				return;
			end
			exp_res = expected_results.pop_front();
			n_checked++;
			if (st !== exp_res.unit_state) begin
				$display("%0t: unit_state expected %0d actual %0d", $time, exp_res.unit_state, st);
				errors++;
			end
			if (ch !== exp_res.changed) begin
				$display("%0t: changed expected %0d actual %0d", $time, exp_res.changed, ch);
				errors++;
			end
			if (fs !== exp_res.field_sum) begin
				$display("%0t: field_sum expected %0d actual %0d", $time, exp_res.field_sum, fs);
				errors++;
			end
		endfunction
	endclass

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic signed [SUM_W-1:0] cfg_data;
	logic                    in_valid;
	logic                    in_ready;
	logic [REQ_W-1:0]        req_type;
	logic [IDX_IN_W-1:0]     unit_index;
	logic                    bit_value;
	logic                    out_valid;
	logic                    out_ready;
	logic                    unit_state;
	logic                    changed;
	logic signed [SUM_W-1:0] field_sum;

	hopfield_predictor predictor;

	// Percentages of cycles in which each side idles, and a pending receiver hold-off.
	int send_idle_pct;
	int recv_idle_pct;
	int hold_left;
	int cycle_count;
	int commits_left;
	int clears_left;

	hopfield_associative_memory #(
		.UNITS        (UNITS),
		.PATTERN_LIMIT(PATTERN_LIMIT)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.unit_index(unit_index),
		.bit_value (bit_value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.unit_state(unit_state),
		.changed   (changed),
		.field_sum (field_sum)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// The watchdog ends a hung run; it counts from time zero, so the clearing pass after
	// reset is inside the budget.
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d results still outstanding",
				$time, cycle_count, predictor.expected_results.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// The receiver decides its ready at each falling edge. A hold-off requested by the
	// stimulus keeps it low for a long stretch, counted here, so that the block backs up
	// and stops taking requests while the sender keeps offering them.
	initial out_ready = 1'b0;
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Every result transfer is checked against the oldest prediction at the rising edge.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			predictor.check_result(unit_state, changed, field_sum);
	end

	// Offers one request, with random idle cycles ahead of it, and holds it until the
	// transfer. The prediction is made at the edge where the block takes the request.
	task automatic send_req(input logic [REQ_W-1:0] req, input logic [IDX_IN_W-1:0] idx,
		input logic bv);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		req_type   <= req;
		unit_index <= idx;
		bit_value  <= bv;
		do
			@(posedge clk);
		while (!in_ready);
		predictor.note_request(req, idx, bv);
	endtask

	// Stops offering requests and waits until every predicted result has come back, then
	// lets the block settle.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (predictor.expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Only called while no request is in flight. The block takes a threshold write at any
	// such time, its clearing pass after reset included; the loop still waits for ready.
	task automatic write_threshold(input logic signed [SUM_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		predictor.set_threshold(value);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic rand_update();
		send_req(REQ_UPDATE, IDX_IN_W'($urandom_range(UNITS - 1)), 1'($urandom));
	endtask

	// Random traffic. Most of it is recall work: states are primed and units updated
	// against the stored weights. Pattern edits followed by a commit are rare because each
	// commit sweeps the whole store; the spare codes and stray loads act as noise.
	task automatic run_random(input int n_items);
		int n;
		int sel;
		int k;
		n = 0;
		while (n < n_items) begin
			sel = $urandom_range(99);
			if (sel < 8 && commits_left > 0) begin
				// Nudge a few pattern bits so that successive commits mostly agree and
				// the weights climb to their limit.
				k = $urandom_range(1, 10);
				repeat (k)
					send_req(REQ_LOAD, IDX_IN_W'($urandom_range(UNITS - 1)), 1'($urandom));
				send_req(REQ_COMMIT, IDX_IN_W'($urandom), 1'($urandom));
				commits_left--;
				n += k + 1;
			end else if (sel < 10 && clears_left > 0) begin
				send_req(REQ_CLEAR, IDX_IN_W'($urandom), 1'($urandom));
				clears_left--;
				n++;
			end else if (sel < 45) begin
				k = $urandom_range(1, 6);
				repeat (k)
					send_req(REQ_SET, IDX_IN_W'($urandom_range(UNITS - 1)), 1'($urandom));
				repeat ($urandom_range(1, 4)) begin
					rand_update();
					n++;
				end
				n += k;
			end else if (sel < 70) begin
				rand_update();
				n++;
			end else if (sel < 82) begin
				send_req(REQ_READ, IDX_IN_W'($urandom), 1'($urandom));
				n++;
			end else if (sel < 92) begin
				send_req(REQ_SET, IDX_IN_W'($urandom), 1'($urandom));
				n++;
			end else if (sel < 96) begin
				send_req(REQ_LOAD, IDX_IN_W'($urandom), 1'($urandom));
				n++;
			end else begin
				send_req(($urandom_range(1)) ? REQ_SPARE_B : REQ_SPARE_A,
					IDX_IN_W'($urandom), 1'($urandom));
				n++;
			end
		end
	endtask

	initial begin
		logic signed [SUM_W-1:0] phase_threshold [6];

		predictor     = new();
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		in_valid      = 1'b0;
		req_type      = REQ_LOAD;
		unit_index    = '0;
		bit_value     = 1'b0;
		hold_left     = 0;
		commits_left  = COMMIT_MAX;
		clears_left   = CLEAR_MAX;
		send_idle_pct = 30;
		recv_idle_pct = 67;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_threshold('0);

		// Directed part: everything on an empty weight store first. With zero weights the
		// sum equals the zero threshold, so an update must leave the unit alone.
		send_req(REQ_READ, 7'd0, 1'b0);
		send_req(REQ_UPDATE, 7'd0, 1'b1);
		send_req(REQ_SET, 7'd127, 1'b1);
		send_req(REQ_READ, 7'd127, 1'b0);
		send_req(REQ_SET, 7'd0, 1'b1);
		// The spare codes must report the unit's state and change nothing.
		send_req(REQ_SPARE_A, 7'd127, 1'b1);
		send_req(REQ_SPARE_B, 7'h55, 1'b0);
		send_req(REQ_SPARE_B, 7'h2A, 1'b1);
		send_req(REQ_UPDATE, 7'd127, 1'b0);
		send_req(REQ_CLEAR, 7'd42, 1'b1);
		send_req(REQ_UPDATE, 7'd127, 1'b1);

		// Fill the whole pattern buffer before the first commit; no commit may ever read
		// a buffer entry that was never loaded.
		for (int i = 0; i < UNITS; i++)
			send_req(REQ_LOAD, IDX_IN_W'(i), (i == 0) ? 1'b1 : (i == UNITS - 1) ? 1'b0 :
				1'($urandom));
		send_req(REQ_COMMIT, 7'd0, 1'b0);
		commits_left--;
		send_req(REQ_SET, 7'd1, 1'b1);
		send_req(REQ_SET, 7'd2, 1'b0);
		send_req(REQ_UPDATE, 7'd0, 1'b0);
		send_req(REQ_UPDATE, 7'd127, 1'b0);
		send_req(REQ_UPDATE, 7'd64, 1'b1);
		send_req(REQ_READ, 7'd64, 1'b0);

		// Random phases, each behind a full drain so the threshold changes while idle.
		// The threshold extremes sit beyond any reachable sum; the small ones make ties
		// and flips likely.
		phase_threshold[0] = SUM_W'($urandom_range(200)) - 12'sd100;
		phase_threshold[1] = SUM_MIN;
		phase_threshold[2] = SUM_MAX;
		phase_threshold[3] = '0;
		phase_threshold[4] = SUM_W'($urandom_range(60)) - 12'sd30;
		phase_threshold[5] = SUM_W'($urandom);

		for (int ph = 0; ph < 6; ph++) begin
			drain();
			write_threshold(phase_threshold[ph]);
			case (ph / 2)
				0: begin
					send_idle_pct = 30;
					recv_idle_pct = 67;
				end
				1: begin
					send_idle_pct = 67;
					recv_idle_pct = 30;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			// Once, starve the output for a long stretch while requests keep coming.
			if (ph == 1)
				hold_left = 400;
			run_random(PHASE_ITEMS);
		end

		drain();
		$display("Checked %0d results: %0d updates with %0d flips and %0d ties at threshold,",
			predictor.n_checked, predictor.n_updates, predictor.n_flips, predictor.n_ties);
		$display("%0d commits, %0d clears, %0d threshold settings, %0d errors.",
			predictor.n_commits, predictor.n_clears, predictor.n_thresholds, predictor.errors);
		if (predictor.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: filelist.f
hdl/hop_pkg.sv
hdl/hop_store.sv
hdl/hopfield_associative_memory.sv
dv/hopfield_associative_memory_tb.sv
